>>> src/qte_pkg.sv
// qte_pkg: widths, fixed-point constants and the arctangent table for the
// quaternion to euler angle core. No dependencies.
package qte_pkg;

	// field widths
	localparam int IN_W    = 16;
	localparam int OUT_W   = 16;
	localparam int PITCH_W = 15;

	// internal widths
	localparam int PROD_W   = 32;  // q2.14 times q2.14, q28
	localparam int ARG_W    = 35;  // 2*(a+b) and 1-2*(a+b) in q28
	localparam int SPN_W    = 29;  // unsaturated pitch argument, |sp| < 2^28
	localparam int SQ_W     = 57;  // sp^2 and 1-sp^2 in q56
	localparam int ROOT_W   = 29;  // floor sqrt of a q56 value up to 1.0
	localparam int CORDIC_W = 37;  // cordic x/y with gain headroom
	localparam int ANG_W    = 24;  // cordic angle accumulator, q20 radians
	localparam int ATAN_LEN = 24;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_STEPS_MAX = 24;

	localparam logic signed [ARG_W-1:0] ONE_Q28     = ARG_W'(64'sd268435456);
	localparam logic signed [ARG_W-1:0] NEG_ONE_Q28 = -ONE_Q28;
	localparam logic [SQ_W-1:0]         ONE_Q56     = SQ_W'(1) << 56;

	localparam logic signed [ANG_W-1:0] PI_Q20      = ANG_W'(32'sd3294199);
	localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = ANG_W'(32'sd1647099);
	localparam logic signed [ANG_W-1:0] ROUND_Q20   = ANG_W'(32'sd64);
	localparam int                      Q20_TO_Q13  = 7;

	localparam logic signed [OUT_W-1:0]   PI_Q13      = OUT_W'(32'sd25736);
	localparam logic signed [PITCH_W-1:0] HALF_PI_Q13 = PITCH_W'(32'sd12868);

	// pitch argument saturation
	typedef enum logic [1:0] {
		PSAT_NONE = 2'd0,
		PSAT_POS  = 2'd1,
		PSAT_NEG  = 2'd2
	} pitch_sat_t;

	// atan(2^-i) in q20 radians, rounded to nearest
	function automatic logic signed [ANG_W-1:0] atan_q20(input int unsigned idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			0:  v = ANG_W'(32'sd823550);
			1:  v = ANG_W'(32'sd486170);
			2:  v = ANG_W'(32'sd256879);
			3:  v = ANG_W'(32'sd130396);
			4:  v = ANG_W'(32'sd65451);
			5:  v = ANG_W'(32'sd32757);
			6:  v = ANG_W'(32'sd16383);
			7:  v = ANG_W'(32'sd8192);
			8:  v = ANG_W'(32'sd4096);
			9:  v = ANG_W'(32'sd2048);
			10: v = ANG_W'(32'sd1024);
			11: v = ANG_W'(32'sd512);
			12: v = ANG_W'(32'sd256);
			13: v = ANG_W'(32'sd128);
			14: v = ANG_W'(32'sd64);
			15: v = ANG_W'(32'sd32);
			16: v = ANG_W'(32'sd16);
			17: v = ANG_W'(32'sd8);
			18: v = ANG_W'(32'sd4);
			19: v = ANG_W'(32'sd2);
			20: v = ANG_W'(32'sd1);
			21: v = ANG_W'(32'sd1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> src/qte_if.sv
// qte_if: valid/ready channel interfaces for quaternion input and euler output.
// Depends on qte_pkg.
interface qte_quat_if;
	logic                              valid;
	logic                              ready;
	logic signed [qte_pkg::IN_W-1:0]   quat_w;
	logic signed [qte_pkg::IN_W-1:0]   quat_x;
	logic signed [qte_pkg::IN_W-1:0]   quat_y;
	logic signed [qte_pkg::IN_W-1:0]   quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
	logic                               valid;
	logic                               ready;
	logic signed [qte_pkg::OUT_W-1:0]   roll_angle;
	logic signed [qte_pkg::PITCH_W-1:0] pitch_angle;
	logic signed [qte_pkg::OUT_W-1:0]   yaw_angle;

	modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

>>> src/qte_isqrt.sv
// qte_isqrt: pipelined floor square root, one result bit per stage.
// Depends on qte_pkg.
module qte_isqrt (
	input  logic                             clk,
	input  logic                             en,
	input  logic [qte_pkg::SQ_W-1:0]         rad,
	output logic [qte_pkg::ROOT_W-1:0]       root
);
	localparam int NB = qte_pkg::ROOT_W;
	localparam int W  = qte_pkg::SQ_W + 2;

	logic [qte_pkg::SQ_W-1:0] rem_s [0:NB];
	logic [NB-1:0]            rt_s  [0:NB];

	assign rem_s[0] = rad;
	assign rt_s[0]  = '0;

	// stage j decides root bit k, remainder stays rad - root^2
	for (genvar j = 0; j < NB; j++) begin : g_bit
		localparam int K = NB - 1 - j;
		logic [W-1:0] trial;
		logic         take;

		assign trial = (W'(rt_s[j]) << (K + 1)) + (W'(1) << (2 * K));
		assign take  = W'(rem_s[j]) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				if (take) begin
					rem_s[j+1] <= qte_pkg::SQ_W'(W'(rem_s[j]) - trial);
					rt_s[j+1]  <= rt_s[j] | (NB'(1) << K);
				end else begin
					rem_s[j+1] <= rem_s[j];
					rt_s[j+1]  <= rt_s[j];
				end
			end
		end
	end

	assign root = rt_s[NB];
endmodule

>>> src/qte_cordic.sv
// qte_cordic: pipelined vectoring cordic, atan2(y, x) to q3.13 radians.
// Depends on qte_pkg.
module qte_cordic #(
	parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [qte_pkg::ARG_W-1:0]  y_in,
	input  logic signed [qte_pkg::ARG_W-1:0]  x_in,
	output logic signed [qte_pkg::OUT_W-1:0]  angle
);
	localparam int CW = qte_pkg::CORDIC_W;
	localparam int AW = qte_pkg::ANG_W;

	logic signed [CW-1:0] cx_s [0:STEPS];
	logic signed [CW-1:0] cy_s [0:STEPS];
	logic signed [AW-1:0] cz_s [0:STEPS];
	logic                 zero_s [0:STEPS];

	logic signed [CW-1:0] xe, ye, x0, y0;
	logic signed [AW-1:0] z0;

	// pre-rotation into the right half plane
	always_comb begin
		xe = CW'(x_in);
		ye = CW'(y_in);
		x0 = xe;
		y0 = ye;
		z0 = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				x0 = ye;
				y0 = -xe;
				z0 = qte_pkg::HALF_PI_Q20;
			end else begin
				x0 = -ye;
				y0 = xe;
				z0 = -qte_pkg::HALF_PI_Q20;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0]   <= x0;
			cy_s[0]   <= y0;
			cz_s[0]   <= z0;
			zero_s[0] <= (x_in == '0) && (y_in == '0);
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [CW-1:0] xs, ys;
		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (cy_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] + ys;
					cy_s[i+1] <= cy_s[i] - xs;
					cz_s[i+1] <= cz_s[i] + qte_pkg::atan_q20(i);
				end else begin
					cx_s[i+1] <= cx_s[i] - ys;
					cy_s[i+1] <= cy_s[i] + xs;
					cz_s[i+1] <= cz_s[i] - qte_pkg::atan_q20(i);
				end
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	// clamp, round q20 to q13, clamp again
	logic signed [AW-1:0] zc, zr, zq;
	logic signed [qte_pkg::OUT_W-1:0] ang_d;

	always_comb begin
		zc = cz_s[STEPS];
		if (zc > qte_pkg::PI_Q20) zc = qte_pkg::PI_Q20;
		if (zc < -qte_pkg::PI_Q20) zc = -qte_pkg::PI_Q20;
		zr = (zc + qte_pkg::ROUND_Q20) >>> qte_pkg::Q20_TO_Q13;
		zq = zr;
		if (zr > AW'(qte_pkg::PI_Q13)) zq = AW'(qte_pkg::PI_Q13);
		if (zr < -AW'(qte_pkg::PI_Q13)) zq = -AW'(qte_pkg::PI_Q13);
		ang_d = zero_s[STEPS] ? '0 : zq[qte_pkg::OUT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= ang_d;
		end
	end
endmodule

>>> src/quaternion_to_euler_core.sv
// quaternion_to_euler_core: zyx euler angles from a q2.14 attitude quaternion.
// Depends on qte_pkg, qte_if, qte_isqrt and qte_cordic.
//
//  channel  dir  payload                                  handshake
//  quat     in   quat_w, quat_x, quat_y, quat_z (q2.14)   valid/ready
//  euler    out  roll_angle, pitch_angle, yaw_angle       valid/ready
//
// one item per cycle unless a held result stalls the pipeline; products and sums,
// then the 29-stage square root, the cordic stages and the output register.
// arst_n clears the valid bits only; data registers are not reset.
// a held result stalls the whole pipeline in place; quat.ready drops only
// while euler holds a result that is not taken.
module quaternion_to_euler_core #(
	parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	qte_quat_if.sink    quat,
	qte_euler_if.source euler
);
	localparam int PW = qte_pkg::PROD_W;
	localparam int AW = qte_pkg::ARG_W;
	localparam int SL = qte_pkg::ROOT_W;
	localparam int CL = CORDIC_STEPS + 2;

	logic en;
	logic out_vld_q;

	assign en         = !out_vld_q || euler.ready;
	assign quat.ready = en;

	// stage 1: products
	logic signed [PW-1:0] wx_s1, yz_s1, wz_s1, xy_s1, wy_s1, zx_s1, xx_s1, yy_s1, zz_s1;
	logic                 vld_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= PW'(quat.quat_w * quat.quat_x);
			yz_s1 <= PW'(quat.quat_y * quat.quat_z);
			wz_s1 <= PW'(quat.quat_w * quat.quat_z);
			xy_s1 <= PW'(quat.quat_x * quat.quat_y);
			wy_s1 <= PW'(quat.quat_w * quat.quat_y);
			zx_s1 <= PW'(quat.quat_z * quat.quat_x);
			xx_s1 <= PW'(quat.quat_x * quat.quat_x);
			yy_s1 <= PW'(quat.quat_y * quat.quat_y);
			zz_s1 <= PW'(quat.quat_z * quat.quat_z);
		end
	end

	// stage 2: numerators and denominators in q28
	logic signed [AW-1:0] sr_s2, cr_s2, sy_s2, cy_s2, sp_s2;
	logic                 vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s2 <= (AW'(wx_s1) + AW'(yz_s1)) <<< 1;
			cr_s2 <= qte_pkg::ONE_Q28 - ((AW'(xx_s1) + AW'(yy_s1)) <<< 1);
			sy_s2 <= (AW'(wz_s1) + AW'(xy_s1)) <<< 1;
			cy_s2 <= qte_pkg::ONE_Q28 - ((AW'(yy_s1) + AW'(zz_s1)) <<< 1);
			sp_s2 <= (AW'(wy_s1) - AW'(zx_s1)) <<< 1;
		end
	end

	// stage 3: pitch saturation and sp^2
	logic signed [qte_pkg::SPN_W-1:0]     spn;
	logic signed [2*qte_pkg::SPN_W-1:0]   sp_sq;
	qte_pkg::pitch_sat_t                  sat_d;
	logic signed [AW-1:0]                 sr_s3, cr_s3, sy_s3, cy_s3, sp_s3;
	logic [qte_pkg::SQ_W-1:0]             sq_s3;
	qte_pkg::pitch_sat_t                  sat_s3;
	logic                                 vld_s3;

	always_comb begin
		if (sp_s2 >= qte_pkg::ONE_Q28) sat_d = qte_pkg::PSAT_POS;
		else if (sp_s2 <= qte_pkg::NEG_ONE_Q28) sat_d = qte_pkg::PSAT_NEG;
		else sat_d = qte_pkg::PSAT_NONE;
		spn   = (sat_d == qte_pkg::PSAT_NONE) ? sp_s2[qte_pkg::SPN_W-1:0] : '0;
		sp_sq = spn * spn;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s3  <= sr_s2;
			cr_s3  <= cr_s2;
			sy_s3  <= sy_s2;
			cy_s3  <= cy_s2;
			sp_s3  <= sp_s2;
			sq_s3  <= sp_sq[qte_pkg::SQ_W-1:0];
			sat_s3 <= sat_d;
		end
	end

	// stage 4: radicand 1 - sp^2 in q56
	logic signed [AW-1:0]     sr_s4, cr_s4, sy_s4, cy_s4, sp_s4;
	logic [qte_pkg::SQ_W-1:0] rad_s4;
	qte_pkg::pitch_sat_t      sat_s4;
	logic                     vld_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s4  <= sr_s3;
			cr_s4  <= cr_s3;
			sy_s4  <= sy_s3;
			cy_s4  <= cy_s3;
			sp_s4  <= sp_s3;
			rad_s4 <= qte_pkg::ONE_Q56 - sq_s3;
			sat_s4 <= sat_s3;
		end
	end

	// square root, operands ride alongside
	logic [qte_pkg::ROOT_W-1:0] root;

	qte_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s4),
		.root (root)
	);

	logic signed [AW-1:0] dl_sr_s [0:SL-1];
	logic signed [AW-1:0] dl_cr_s [0:SL-1];
	logic signed [AW-1:0] dl_sy_s [0:SL-1];
	logic signed [AW-1:0] dl_cy_s [0:SL-1];
	logic signed [AW-1:0] dl_sp_s [0:SL-1];
	qte_pkg::pitch_sat_t  dl_sat_s [0:SL-1];
	logic [SL-1:0]        dl_vld_s;

	always_ff @(posedge clk) begin
		if (en) begin
			dl_sr_s[0]  <= sr_s4;
			dl_cr_s[0]  <= cr_s4;
			dl_sy_s[0]  <= sy_s4;
			dl_cy_s[0]  <= cy_s4;
			dl_sp_s[0]  <= sp_s4;
			dl_sat_s[0] <= sat_s4;
			for (int i = 1; i < SL; i++) begin
				dl_sr_s[i]  <= dl_sr_s[i-1];
				dl_cr_s[i]  <= dl_cr_s[i-1];
				dl_sy_s[i]  <= dl_sy_s[i-1];
				dl_cy_s[i]  <= dl_cy_s[i-1];
				dl_sp_s[i]  <= dl_sp_s[i-1];
				dl_sat_s[i] <= dl_sat_s[i-1];
			end
		end
	end

	// three cordics in parallel
	logic signed [qte_pkg::OUT_W-1:0] roll_ang, pitch_ang, yaw_ang;
	logic signed [AW-1:0]             pitch_x;

	assign pitch_x = $signed(AW'(root));

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk (clk), .en (en), .y_in (dl_sr_s[SL-1]), .x_in (dl_cr_s[SL-1]), .angle (roll_ang)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk (clk), .en (en), .y_in (dl_sy_s[SL-1]), .x_in (dl_cy_s[SL-1]), .angle (yaw_ang)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk (clk), .en (en), .y_in (dl_sp_s[SL-1]), .x_in (pitch_x), .angle (pitch_ang)
	);

	qte_pkg::pitch_sat_t cd_sat_s [0:CL-1];
	logic [CL-1:0]       cd_vld_s;

	always_ff @(posedge clk) begin
		if (en) begin
			cd_sat_s[0] <= dl_sat_s[SL-1];
			for (int i = 1; i < CL; i++) begin
				cd_sat_s[i] <= cd_sat_s[i-1];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			dl_vld_s  <= '0;
			cd_vld_s  <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= quat.valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			dl_vld_s  <= {dl_vld_s[SL-2:0], vld_s4};
			cd_vld_s  <= {cd_vld_s[CL-2:0], dl_vld_s[SL-1]};
			out_vld_q <= cd_vld_s[CL-1];
		end
	end

	// output register, pitch saturation applied here
	logic signed [qte_pkg::PITCH_W-1:0] pitch_d;
	logic signed [qte_pkg::OUT_W-1:0]   roll_q, yaw_q;
	logic signed [qte_pkg::PITCH_W-1:0] pitch_q;

	always_comb begin
		case (cd_sat_s[CL-1])
			qte_pkg::PSAT_POS: pitch_d = qte_pkg::HALF_PI_Q13;
			qte_pkg::PSAT_NEG: pitch_d = -qte_pkg::HALF_PI_Q13;
			default: begin
				if (pitch_ang > qte_pkg::OUT_W'(qte_pkg::HALF_PI_Q13))
					pitch_d = qte_pkg::HALF_PI_Q13;
				else if (pitch_ang < -qte_pkg::OUT_W'(qte_pkg::HALF_PI_Q13))
					pitch_d = -qte_pkg::HALF_PI_Q13;
				else
					pitch_d = pitch_ang[qte_pkg::PITCH_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q  <= roll_ang;
			yaw_q   <= yaw_ang;
			pitch_q <= pitch_d;
		end
	end

	assign euler.valid       = out_vld_q;
	assign euler.roll_angle  = roll_q;
	assign euler.pitch_angle = pitch_q;
	assign euler.yaw_angle   = yaw_q;

`ifndef SYNTHESIS
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		euler.valid |-> (euler.pitch_angle <= qte_pkg::HALF_PI_Q13 &&
			euler.pitch_angle >= -qte_pkg::HALF_PI_Q13))
		else $error("pitch out of range");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		euler.valid |-> (euler.roll_angle <= qte_pkg::PI_Q13 &&
			euler.roll_angle >= -qte_pkg::PI_Q13 &&
			euler.yaw_angle <= qte_pkg::PI_Q13 && euler.yaw_angle >= -qte_pkg::PI_Q13))
		else $error("roll or yaw out of range");

	a_sat_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(en && cd_vld_s[CL-1] && cd_sat_s[CL-1] == qte_pkg::PSAT_POS) |=>
			(euler.pitch_angle == qte_pkg::HALF_PI_Q13))
		else $error("saturated pitch not at plus pi/2");

	a_sat_sq: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && sat_s3 != qte_pkg::PSAT_NONE) |-> (sq_s3 == '0))
		else $error("square of saturated pitch argument not cleared");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dl_vld_s[SL-1] |-> (root <= qte_pkg::ROOT_W'(1) << 28))
		else $error("square root above one");
`endif

endmodule

>>> verif/quaternion_to_euler_core_tb.sv
// quaternion_to_euler_core_tb: random and directed quaternions checked against a
// fixed-point zyx euler angle predictor. Depends on qte_pkg, qte_if and the core.
`timescale 1ns / 1ps

module quaternion_to_euler_core_tb;

	localparam int STEPS     = qte_pkg::CORDIC_STEPS_DEF;
	localparam int LATENCY   = STEPS + 36;
	localparam int MAX_CYCLE = 400000;

	typedef struct {
		logic signed [qte_pkg::IN_W-1:0] w, x, y, z;
	} quat_item_t;

	typedef struct {
		logic signed [qte_pkg::OUT_W-1:0]   roll;
		logic signed [qte_pkg::PITCH_W-1:0] pitch;
		logic signed [qte_pkg::OUT_W-1:0]   yaw;
	} euler_item_t;

	logic clk;
	logic arst_n;

	qte_quat_if  quat ();
	qte_euler_if euler ();

	quaternion_to_euler_core #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n), .quat(quat), .euler(euler)
	);

	quat_item_t  pending_quats[$];
	euler_item_t expected_angles[$];
	int          error_count;
	int          cycle_count;
	int          send_gap;
	int          take_gap;
	bit          hold_send;
	bit          stimulus_done;

	// floor shift for signed values
	function automatic longint floor_shift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -(((-v) - 1) >>> s) - 1;
	endfunction

	function automatic longint limit_to(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint atan_step(int i);
		longint tab[24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
			4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 1, 0, 0};
		return tab[i];
	endfunction

	// vectoring cordic angle in q13
	function automatic longint cordic_angle(longint num, longint den);
		longint ang, t, xs, ys;
		ang = 0;
		if (num == 0 && den == 0)
			return 0;
		if (den < 0) begin
			t = den;
			if (num >= 0) begin
				den = num; num = -t; ang = qte_pkg::HALF_PI_Q20;
			end else begin
				den = -num; num = t; ang = -qte_pkg::HALF_PI_Q20;
			end
		end
		for (int i = 0; i < STEPS && i < qte_pkg::ATAN_LEN; i++) begin
			xs = floor_shift(den, i);
			ys = floor_shift(num, i);
			if (num >= 0) begin
				den = den + ys; num = num - xs; ang += atan_step(i);
			end else begin
				den = den - ys; num = num + xs; ang -= atan_step(i);
			end
		end
		ang = limit_to(ang, qte_pkg::PI_Q20);
		return limit_to(floor_shift(ang + 64, 7), qte_pkg::PI_Q13);
	endfunction

	function automatic longint floor_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b; res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic euler_item_t euler_of(quat_item_t q);
		euler_item_t e;
		longint w, x, y, z, sr, cr, sy, cy, sp, p;
		longint one;
		one = 64'sd1 << 28;
		w = q.w; x = q.x; y = q.y; z = q.z;
		sr = 2 * (w * x + y * z);
		cr = one - 2 * (x * x + y * y);
		sy = 2 * (w * z + x * y);
		cy = one - 2 * (y * y + z * z);
		sp = 2 * (w * y - z * x);
		if (sp >= one)
			p = qte_pkg::HALF_PI_Q13;
		else if (sp <= -one)
			p = -qte_pkg::HALF_PI_Q13;
		else
			p = limit_to(cordic_angle(sp, floor_sqrt((64'd1 << 56) - sp * sp)),
				qte_pkg::HALF_PI_Q13);
		e.roll  = qte_pkg::OUT_W'(cordic_angle(sr, cr));
		e.pitch = qte_pkg::PITCH_W'(p);
		e.yaw   = qte_pkg::OUT_W'(cordic_angle(sy, cy));
		return e;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	function automatic int random_gap();
		if ($urandom_range(0, 2) == 0)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	task automatic add_quat(int w, int x, int y, int z);
		quat_item_t q;
		q.w = qte_pkg::IN_W'(w);
		q.x = qte_pkg::IN_W'(x);
		q.y = qte_pkg::IN_W'(y);
		q.z = qte_pkg::IN_W'(z);
		pending_quats.push_back(q);
	endtask

	// random unit-ish quaternion via normalization
	task automatic add_unit_quat();
		real a, b, c, d, n;
		a = $urandom_range(0, 65534) - 32767.0;
		b = $urandom_range(0, 65534) - 32767.0;
		c = $urandom_range(0, 65534) - 32767.0;
		d = $urandom_range(0, 65534) - 32767.0;
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n < 1.0)
			n = 1.0;
		add_quat(int'(a / n * 16384.0), int'(b / n * 16384.0),
			int'(c / n * 16384.0), int'(d / n * 16384.0));
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLE) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat.valid <= 1'b0;
			send_gap   <= 0;
		end else begin
			if (quat.valid && quat.ready) begin
				expected_angles.push_back(euler_of(quat_item_t'{quat.quat_w,
					quat.quat_x, quat.quat_y, quat.quat_z}));
			end
			if (!quat.valid || quat.ready) begin
				if (send_gap > 0 || hold_send || pending_quats.size() == 0) begin
					quat.valid <= 1'b0;
					if (send_gap > 0)
						send_gap <= send_gap - 1;
				end else begin
					quat_item_t q;
					q = pending_quats.pop_front();
					quat.valid  <= 1'b1;
					quat.quat_w <= q.w;
					quat.quat_x <= q.x;
					quat.quat_y <= q.y;
					quat.quat_z <= q.z;
					send_gap    <= random_gap();
				end
			end
		end
	end

	// monitor and result stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			euler.ready <= 1'b0;
			take_gap    <= 0;
		end else begin
			if (euler.valid && euler.ready) begin
				if (expected_angles.size() == 0) begin
					$display("unexpected result");
					error_count++;
				end else begin
					euler_item_t e;
					e = expected_angles.pop_front();
					if (euler.roll_angle !== e.roll)
						report_mismatch("roll", euler.roll_angle, e.roll);
					if (euler.pitch_angle !== e.pitch)
						report_mismatch("pitch", euler.pitch_angle, e.pitch);
					if (euler.yaw_angle !== e.yaw)
						report_mismatch("yaw", euler.yaw_angle, e.yaw);
				end
			end
			if (take_gap > 0) begin
				euler.ready <= 1'b0;
				take_gap    <= take_gap - 1;
			end else begin
				euler.ready <= 1'b1;
				take_gap    <= random_gap();
			end
		end
	end

	initial begin
		int v;
		error_count   = 0;
		cycle_count   = 0;
		hold_send     = 1'b0;
		stimulus_done = 1'b0;
		arst_n        = 1'b0;
		quat.valid    = 1'b0;
		quat.quat_w   = '0;
		quat.quat_x   = '0;
		quat.quat_y   = '0;
		quat.quat_z   = '0;
		euler.ready   = 1'b0;

		// directed: identity, extremes, zero atan2 operands, negative denominators,
		// pitch saturation upwards and just short of it both ways, out of range components
		add_quat(16384, 0, 0, 0);
		add_quat(0, 0, 0, 0);
		add_quat(-16384, 0, 0, 0);
		add_quat(0, 16384, 0, 0);
		add_quat(0, 0, 16384, 0);
		add_quat(0, 0, 0, 16384);
		add_quat(11585, 0, 11585, 0);
		add_quat(11585, 0, -11585, 0);
		add_quat(11586, 0, 11586, 0);
		add_quat(11585, 11585, 0, 0);
		add_quat(11585, -11585, 0, 0);
		add_quat(0, 11585, 0, 11585);
		add_quat(16384, 16384, 16384, 16384);
		add_quat(-16384, -16384, -16384, -16384);
		add_quat(32767, 32767, 32767, 32767);
		add_quat(-32768, -32768, -32768, -32768);
		add_quat(32767, -32768, 32767, -32768);
		add_quat(0, 0, 5000, 0);
		add_quat(1, -1, 1, -1);
		add_quat(8192, 8192, 8192, 8192);
		add_quat(8192, -8192, 8192, 8192);

		#1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// pause the sender until the pipeline drains
		wait (pending_quats.size() == 0);
		@(posedge clk);
		hold_send <= 1'b1;
		wait (expected_angles.size() == 0 && !quat.valid);
		repeat (LATENCY) @(posedge clk);
		hold_send <= 1'b0;

		// random: mostly unit quaternions, some raw full-range words, some components in +-1.0
		for (int i = 0; i < 700; i++) begin
			if ($urandom_range(0, 3) != 0)
				add_unit_quat();
			else begin
				v = $urandom_range(0, 3);
				if (v == 0)
					add_quat($urandom, $urandom, $urandom, $urandom);
				else
					add_quat($urandom_range(0, 32768) - 16384,
						$urandom_range(0, 32768) - 16384,
						$urandom_range(0, 32768) - 16384,
						$urandom_range(0, 32768) - 16384);
			end
		end

		wait (pending_quats.size() == 0);
		@(posedge clk);
		wait (!quat.valid && expected_angles.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
